>>> rtl/url_component_splitter_top_assert.svh
// Assertion macros shared by the URL splitter RTL.
`ifndef URL_COMPONENT_SPLITTER_TOP_ASSERT_SVH
`define URL_COMPONENT_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define UCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ucs_pkg.sv
// Shared types and constants for the URL component splitter.
package ucs_pkg;

  localparam int MAX_LEN = 4096;
  // Offsets reach MAX_LEN itself (one past the last byte).
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int NUM_BO  = 10;

  // Job queue between parser and span emitter (power of two).
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Boundary offset slots
  localparam int BO_SCHEME_END = 0;
  localparam int BO_AUTH       = 1;
  localparam int BO_COLON      = 2;
  localparam int BO_AT         = 3;
  localparam int BO_HOST       = 4;
  localparam int BO_HOST_END   = 5;
  localparam int BO_PORT       = 6;
  localparam int BO_PATH       = 7;
  localparam int BO_QUERY      = 8;
  localparam int BO_FRAG       = 9;

  // Component codes
  localparam logic [2:0] COMP_SCHEME   = 3'd0;
  localparam logic [2:0] COMP_USER     = 3'd1;
  localparam logic [2:0] COMP_PASSWORD = 3'd2;
  localparam logic [2:0] COMP_HOST     = 3'd3;
  localparam logic [2:0] COMP_PORT     = 3'd4;
  localparam logic [2:0] COMP_PATH     = 3'd5;
  localparam logic [2:0] COMP_QUERY    = 3'd6;
  localparam logic [2:0] COMP_FRAGMENT = 3'd7;

  typedef struct packed {
    logic [7:0] url_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  component;
    logic [11:0] span_start;
    logic [12:0] span_length;
    logic        url_valid;
    logic        run_end;
  } out_item_t;

  typedef logic [POS_W-1:0] pos_t;

  // One finished URL handed from parser to emitter
  typedef struct packed {
    logic                       bad;
    logic                       user;
    logic                       colon;
    logic                       pass;
    logic                       port;
    logic                       query;
    logic                       frag;
    pos_t                       n;
    logic [NUM_BO-1:0][POS_W-1:0] bo;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

>>> rtl/ucs_front.sv
// Byte-serial URL parser: tracks delimiters and builds one job per URL.
module ucs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ucs_pkg::in_item_t  in_data,
  input  ucs_pkg::queue_stat_t q_stat,
  output logic               push,
  output ucs_pkg::job_t      push_job
);

  localparam logic [3:0] PH_SCHEME     = 4'd0;
  localparam logic [3:0] PH_SL1        = 4'd1;
  localparam logic [3:0] PH_SL2        = 4'd2;
  localparam logic [3:0] PH_HOST_FIRST = 4'd3;
  localparam logic [3:0] PH_HOST       = 4'd4;
  localparam logic [3:0] PH_HOST_BR    = 4'd5;
  localparam logic [3:0] PH_AFTER_BR   = 4'd6;
  localparam logic [3:0] PH_PORT       = 4'd7;
  localparam logic [3:0] PH_PATH       = 4'd8;
  localparam logic [3:0] PH_QUERY      = 4'd9;
  localparam logic [3:0] PH_FRAG       = 4'd10;
  localparam logic [3:0] PH_BAD        = 4'd11;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef struct packed {
    logic pending;
    logic ended;
    logic colon;
    logic user;
    logic pass;
    logic port;
    logic query;
    logic frag;
  } seen_t;

  logic [3:0]                   phase_r, phase_nxt;
  ucs_pkg::pos_t                pos_r, pos_nxt;
  logic [ucs_pkg::NUM_BO-1:0][ucs_pkg::POS_W-1:0] bo_r, bo_nxt;
  seen_t                        seen_r, seen_nxt;
  logic                         rej_r, rej_nxt;
  logic                         take;
  logic [7:0]                   c;
  ucs_pkg::pos_t                p1;

  function automatic logic scheme_char(input logic [7:0] ch);
    scheme_char = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A) ||
                  ch == CH_PLUS || ch == CH_MINUS || ch == CH_DOT;
  endfunction

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;
  assign c        = in_data.url_byte;
  assign p1       = pos_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    bo_nxt    = bo_r;
    seen_nxt  = seen_r;
    rej_nxt   = rej_r;
    if (!seen_r.ended) begin
      if (c == CH_NUL) begin
        seen_nxt.ended = 1'b1;
      end else if (pos_r >= ucs_pkg::POS_W'(ucs_pkg::MAX_LEN)) begin
        rej_nxt = 1'b1;
      end else begin
        pos_nxt = p1;
        if (phase_r == PH_SCHEME) begin
          if (c == CH_COLON) begin
            bo_nxt[ucs_pkg::BO_SCHEME_END] = pos_r;
            phase_nxt = PH_SL1;
          end else if (!scheme_char(c)) begin
            rej_nxt = 1'b1;
          end
        end else if (phase_r == PH_SL1) begin
          if (c == CH_SLASH) begin
            phase_nxt = PH_SL2;
          end else begin
            rej_nxt   = 1'b1;
            phase_nxt = PH_BAD;
          end
        end else if (phase_r == PH_SL2) begin
          if (c == CH_SLASH) begin
            bo_nxt[ucs_pkg::BO_AUTH] = p1;
            bo_nxt[ucs_pkg::BO_HOST] = p1;
            seen_nxt.pending = 1'b1;
            phase_nxt = PH_HOST_FIRST;
          end else begin
            rej_nxt   = 1'b1;
            phase_nxt = PH_BAD;
          end
        end else if (seen_r.pending && c == CH_AT) begin
          // userinfo confirmed: host parse restarts after the '@'
          bo_nxt[ucs_pkg::BO_AT]   = pos_r;
          bo_nxt[ucs_pkg::BO_HOST] = p1;
          seen_nxt.user    = 1'b1;
          seen_nxt.pass    = seen_r.pass | seen_r.colon;
          seen_nxt.pending = 1'b0;
          seen_nxt.port    = 1'b0;
          phase_nxt = PH_HOST_FIRST;
        end else begin
          if (seen_r.pending) begin
            if (c == CH_COLON && !seen_r.colon) begin
              bo_nxt[ucs_pkg::BO_COLON] = pos_r;
              seen_nxt.colon = 1'b1;
            end
            if (c == CH_SLASH) seen_nxt.pending = 1'b0;
          end
          unique case (phase_r) inside
            PH_HOST_FIRST, PH_HOST: begin
              if (phase_r == PH_HOST_FIRST && c == CH_LBR) begin
                phase_nxt = PH_HOST_BR;
              end else begin
                phase_nxt = PH_HOST;
                if (c == CH_COLON) begin
                  bo_nxt[ucs_pkg::BO_HOST_END] = pos_r;
                  bo_nxt[ucs_pkg::BO_PORT]     = p1;
                  seen_nxt.port = 1'b1;
                  phase_nxt = PH_PORT;
                end else if (c == CH_SLASH) begin
                  bo_nxt[ucs_pkg::BO_HOST_END] = pos_r;
                  bo_nxt[ucs_pkg::BO_PATH]     = p1;
                  phase_nxt = PH_PATH;
                end
              end
            end
            PH_HOST_BR: begin
              if (c == CH_RBR) begin
                bo_nxt[ucs_pkg::BO_HOST_END] = p1;
                phase_nxt = PH_AFTER_BR;
              end
            end
            PH_AFTER_BR: begin
              if (c == CH_COLON) begin
                bo_nxt[ucs_pkg::BO_PORT] = p1;
                seen_nxt.port = 1'b1;
                phase_nxt = PH_PORT;
              end else if (c == CH_SLASH) begin
                bo_nxt[ucs_pkg::BO_PATH] = p1;
                phase_nxt = PH_PATH;
              end else begin
                phase_nxt = PH_BAD;
              end
            end
            PH_PORT: begin
              if (c == CH_SLASH) begin
                bo_nxt[ucs_pkg::BO_PATH] = p1;
                phase_nxt = PH_PATH;
              end
            end
            PH_PATH: begin
              if (c == CH_QMARK) begin
                bo_nxt[ucs_pkg::BO_QUERY] = p1;
                seen_nxt.query = 1'b1;
                phase_nxt = PH_QUERY;
              end else if (c == CH_HASH) begin
                bo_nxt[ucs_pkg::BO_FRAG] = p1;
                seen_nxt.frag = 1'b1;
                phase_nxt = PH_FRAG;
              end
            end
            PH_QUERY: begin
              if (c == CH_HASH) begin
                bo_nxt[ucs_pkg::BO_FRAG] = p1;
                seen_nxt.frag = 1'b1;
                phase_nxt = PH_FRAG;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_comb begin
    push_job.bad   = rej_nxt || !(phase_nxt == PH_PATH || phase_nxt == PH_QUERY ||
                                  phase_nxt == PH_FRAG);
    push_job.user  = seen_nxt.user;
    push_job.colon = seen_nxt.colon;
    push_job.pass  = seen_nxt.pass;
    push_job.port  = seen_nxt.port;
    push_job.query = seen_nxt.query;
    push_job.frag  = seen_nxt.frag;
    push_job.n     = pos_nxt;
    push_job.bo    = bo_nxt;
  end

  assign push = take && in_data.final_byte;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      phase_r <= PH_SCHEME;
      pos_r   <= '0;
      bo_r    <= '0;
      seen_r  <= '0;
      rej_r   <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      bo_r    <= bo_nxt;
      seen_r  <= seen_nxt;
      rej_r   <= rej_nxt;
    end
  end

endmodule

>>> rtl/ucs_queue.sv
// Small job queue that decouples the parser from the span emitter.
`include "url_component_splitter_top_assert.svh"

module ucs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ucs_pkg::job_t        push_job,
  input  logic                 pop,
  output ucs_pkg::job_t        head,
  output ucs_pkg::queue_stat_t stat
);

  ucs_pkg::job_t                q_r [ucs_pkg::QUEUE_DEPTH];
  logic [ucs_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [ucs_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign stat.full  = (cnt_r == ucs_pkg::QCNT_W'(ucs_pkg::QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= push_job;
  end

  `UCS_ASSERT_NOW(a_q_cnt_bound, 1'b1, cnt_r <= ucs_pkg::QCNT_W'(ucs_pkg::QUEUE_DEPTH), "queue count over depth")
  `UCS_ASSERT_NEXT(a_q_push_lands, do_push && !do_pop, !stat.empty, "pushed job not visible")

endmodule

>>> rtl/ucs_back.sv
// Span emitter: walks the head job's eight components, one per cycle unless out_ready stalls (one result if bad).
`include "url_component_splitter_top_assert.svh"

module ucs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ucs_pkg::job_t        head,
  input  ucs_pkg::queue_stat_t q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ucs_pkg::out_item_t   out_data
);

  localparam int CALC_W = (ucs_pkg::POS_W > 13) ? ucs_pkg::POS_W : 13;

  logic [2:0]          idx_r;
  logic                out_valid_r;
  ucs_pkg::out_item_t  out_data_r;
  ucs_pkg::out_item_t  res;
  ucs_pkg::pos_t       start, minu, f_end, e_end;
  logic [CALC_W-1:0]   start_x, diff_x;
  logic                last, load;

  // Path end is query start minus one, else fragment start minus one, else n
  assign f_end = head.frag  ? head.bo[ucs_pkg::BO_FRAG]  - 1'b1 : head.n;
  assign e_end = head.query ? head.bo[ucs_pkg::BO_QUERY] - 1'b1 : f_end;

  always_comb begin
    start = '0;
    minu  = '0;
    unique case (idx_r)
      ucs_pkg::COMP_SCHEME: begin
        minu = head.bo[ucs_pkg::BO_SCHEME_END];
      end
      ucs_pkg::COMP_USER: begin
        if (head.user) begin
          start = head.bo[ucs_pkg::BO_AUTH];
          minu  = head.colon ? head.bo[ucs_pkg::BO_COLON] : head.bo[ucs_pkg::BO_AT];
        end
      end
      ucs_pkg::COMP_PASSWORD: begin
        if (head.pass) begin
          start = head.bo[ucs_pkg::BO_COLON] + 1'b1;
          minu  = head.bo[ucs_pkg::BO_AT];
        end
      end
      ucs_pkg::COMP_HOST: begin
        start = head.bo[ucs_pkg::BO_HOST];
        minu  = head.bo[ucs_pkg::BO_HOST_END];
      end
      ucs_pkg::COMP_PORT: begin
        if (head.port) begin
          start = head.bo[ucs_pkg::BO_PORT];
          minu  = head.bo[ucs_pkg::BO_PATH] - 1'b1;
        end
      end
      ucs_pkg::COMP_PATH: begin
        start = head.bo[ucs_pkg::BO_PATH];
        minu  = e_end;
      end
      ucs_pkg::COMP_QUERY: begin
        if (head.query) begin
          start = head.bo[ucs_pkg::BO_QUERY];
          minu  = f_end;
        end
      end
      ucs_pkg::COMP_FRAGMENT: begin
        if (head.frag) begin
          start = head.bo[ucs_pkg::BO_FRAG];
          minu  = head.n;
        end
      end
      default: ;
    endcase
  end

  assign start_x = CALC_W'(start);
  assign diff_x  = CALC_W'(minu) - start_x;

  always_comb begin
    if (head.bad) begin
      res.component   = ucs_pkg::COMP_SCHEME;
      res.span_start  = '0;
      res.span_length = '0;
      res.url_valid   = 1'b0;
      res.run_end     = 1'b1;
    end else begin
      res.component   = idx_r;
      res.span_start  = start_x[11:0];
      res.span_length = diff_x[12:0];
      res.url_valid   = 1'b1;
      res.run_end     = (idx_r == ucs_pkg::COMP_FRAGMENT);
    end
  end

  assign last = head.bad || (idx_r == ucs_pkg::COMP_FRAGMENT);
  assign load = !q_stat.empty && (!out_valid_r || out_ready);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= ucs_pkg::COMP_SCHEME;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= last ? ucs_pkg::COMP_SCHEME : idx_r + 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `UCS_ASSERT_NOW(a_reject_ends_run, out_valid_r && !out_data_r.url_valid, out_data_r.run_end, "rejected URL result without run end")
  `UCS_ASSERT_NOW(a_frag_ends_run, out_valid_r && out_data_r.url_valid && out_data_r.component == ucs_pkg::COMP_FRAGMENT, out_data_r.run_end, "fragment span not last")
  `UCS_ASSERT_NEXT(a_run_continues, out_valid_r && out_ready && !out_data_r.run_end, out_valid_r, "gap inside a URL's results")

endmodule

>>> rtl/url_component_splitter_top.sv
// Top level of the URL component splitter.
// Accepts one URL byte per cycle. The parser updates its delimiter registers as
// each byte is taken; on the final byte it queues a job (two-entry queue) and
// is ready for the next URL at once. The emitter then delivers one result per
// cycle while out_ready is not held low: eight spans for a good URL, or one
// rejection result. Input stalls only while both queue entries are occupied,
// i.e. when URLs shorter than about eight bytes arrive back to back or the
// result side is held off. No clearing pass is needed after reset.
module url_component_splitter_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ucs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ucs_pkg::out_item_t out_data
);

  ucs_pkg::job_t        push_job, head;
  ucs_pkg::queue_stat_t q_stat;
  logic                 push, pop;

  ucs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  ucs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  ucs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
